// ----- hdl/scgb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scgb_pkg;

    // Field and register widths
    localparam int W_SIZE   = 14;
    localparam int W_POS    = 13;
    localparam int W_SKIP   = 8;
    localparam int W_BYTE   = 8;
    localparam int W_IDX    = 8;
    localparam int W_SUM    = 27;
    localparam int W_CNT    = 19;
    localparam int W_MEAN   = 8;
    localparam int W_CFG_IX = 2;

    // Serial divider used to rebuild the position trackers
    localparam int W_DVD    = 20;
    localparam int W_DVC    = $clog2(W_DVD);

    // Grid defaults
    localparam int GRID_WIDE_DEF = 16;
    localparam int GRID_HIGH_DEF = 9;

    // Register reset values and limits
    localparam logic [W_SIZE-1:0] WIDTH_RST    = 14'd1920;
    localparam logic [W_SIZE-1:0] HEIGHT_RST   = 14'd1080;
    localparam logic [W_SKIP-1:0] SKIP_RST     = 8'd32;
    localparam logic [W_SIZE-1:0] SIZE_MAX_PIX = 14'd8192;
    localparam logic [W_CNT-1:0]  COUNT_MAX    = 19'h7FFFF;

    typedef enum logic [W_CFG_IX-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_SKIP         = 2'd2
    } t_cfg_idx;

    // Which tracker a divider run rebuilds
    typedef enum logic [1:0] {
        DV_XM = 2'd0,
        DV_YM = 2'd1,
        DV_XB = 2'd2,
        DV_YB = 2'd3
    } t_div_sel;

    typedef enum logic [3:0] {
        S_BOOT_CLR,
        S_IDLE,
        S_CLR,
        S_WRAP,
        S_DIV_GO,
        S_DIV_RUN,
        S_PX_RD,
        S_PX_WR,
        S_ADJ,
        S_RD_ISSUE,
        S_RD_DATA,
        S_MEAN,
        S_OUT
    } t_state;

    // One bucket of the accumulator memory
    typedef struct packed {
        logic [W_SUM-1:0] red;
        logic [W_SUM-1:0] green;
        logic [W_SUM-1:0] blue;
        logic [W_CNT-1:0] count;
    } t_bucket;

    typedef struct packed {
        logic     in_ready;
        logic     pos_clear;
        logic     clr_step;
        logic     wrap;
        logic     div_start;
        t_div_sel div_sel;
        logic     resync_done;
        logic     px_issue;
        logic     px_write;
        logic     adjust;
        logic     rd_issue;
        logic     rd_live;
        logic     rd_capture;
        logic     mean_step;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic in_fs;
        logic held_op;
        logic dirty;
        logic clr_last;
        logic div_done;
        logic adj_need;
        logic mean_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- hdl/scgb_pix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface scgb_pix_if import scgb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic              frame_start;
    logic [W_BYTE-1:0] red;
    logic [W_BYTE-1:0] green;
    logic [W_BYTE-1:0] blue;
    logic [W_IDX-1:0]  bucket_index;

    modport source (
        output valid, operation, frame_start, red, green, blue, bucket_index,
        input  ready
    );
    modport sink (
        input  valid, operation, frame_start, red, green, blue, bucket_index,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/scgb_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface scgb_res_if import scgb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [W_SUM-1:0]  red_sum;
    logic [W_SUM-1:0]  green_sum;
    logic [W_SUM-1:0]  blue_sum;
    logic [W_CNT-1:0]  sample_count;
    logic [W_MEAN-1:0] red_mean;
    logic [W_MEAN-1:0] green_mean;
    logic [W_MEAN-1:0] blue_mean;

    modport source (
        output valid, red_sum, green_sum, blue_sum, sample_count,
               red_mean, green_mean, blue_mean,
        input  ready
    );
    modport sink (
        input  valid, red_sum, green_sum, blue_sum, sample_count,
               red_mean, green_mean, blue_mean,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/scgb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scgb_ctrl import scgb_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state   r_state, n_state;
    t_div_sel r_div_sel, n_div_sel;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_BOOT_CLR;
            r_div_sel <= DV_XM;
        end else begin
            r_state   <= n_state;
            r_div_sel <= n_div_sel;
        end
    end

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_div_sel = r_div_sel;
        o_cmd     = '0;
        o_cmd.div_sel = r_div_sel;
        unique case (r_state)
            S_BOOT_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    if (i_sts.in_fs) begin
                        o_cmd.pos_clear = 1'b1;
                        n_state = S_CLR;
                    end else if (i_sts.in_op) begin
                        o_cmd.rd_issue = 1'b1;
                        o_cmd.rd_live  = 1'b1;
                        n_state = S_RD_DATA;
                    end else if (i_sts.dirty) begin
                        n_state = S_WRAP;
                    end else begin
                        o_cmd.px_issue = 1'b1;
                        n_state = S_PX_WR;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = i_sts.held_op ? S_RD_ISSUE : S_PX_RD;
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_div_sel  = DV_XM;
                n_state    = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (i_sts.div_done) begin
                    unique case (r_div_sel)
                        DV_XM: n_div_sel = DV_YM;
                        DV_YM: n_div_sel = DV_XB;
                        DV_XB: n_div_sel = DV_YB;
                        DV_YB: n_div_sel = DV_YB;
                        default: n_div_sel = DV_XM;
                    endcase
                    if (r_div_sel == DV_YB) begin
                        o_cmd.resync_done = 1'b1;
                        n_state = S_PX_RD;
                    end else begin
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_PX_RD: begin
                o_cmd.px_issue = 1'b1;
                n_state = S_PX_WR;
            end
            S_PX_WR: begin
                o_cmd.px_write = 1'b1;
                n_state = i_sts.adj_need ? S_ADJ : S_IDLE;
            end
            S_ADJ: begin
                if (i_sts.adj_need) o_cmd.adjust = 1'b1;
                else n_state = S_IDLE;
            end
            S_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                o_cmd.rd_capture = 1'b1;
                n_state = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.mean_step = 1'b1;
                if (i_sts.mean_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Read-modify-write of a bucket always completes in the following cycle
    a_px_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.px_issue |=> o_cmd.px_write)
        else $error("pixel read not followed by its write");

endmodule

`default_nettype wire

// ----- hdl/scgb_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scgb_dpath import scgb_pkg::*; #(
    parameter int GRID_WIDE = GRID_WIDE_DEF,
    parameter int GRID_HIGH = GRID_HIGH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [W_CFG_IX-1:0]   i_cfg_idx,
    input  wire  [W_SIZE-1:0]     i_cfg_data,
    scgb_pix_if.sink              i_in,
    scgb_res_if.source            o_out,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts
);

    localparam int BUCKETS = GRID_WIDE * GRID_HIGH;
    localparam int A_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int BX_W    = (GRID_WIDE > 1) ? $clog2(GRID_WIDE) : 1;
    localparam int BY_W    = (GRID_HIGH > 1) ? $clog2(GRID_HIGH) : 1;

    // ---------------- configuration ----------------
    logic [W_SIZE-1:0] r_cfg_w, r_cfg_h;
    logic [W_SKIP-1:0] r_cfg_skip;
    logic              r_dirty;
    logic [W_SIZE-1:0] wc, hc;
    logic [W_SKIP:0]   step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= WIDTH_RST;
            r_cfg_h    <= HEIGHT_RST;
            r_cfg_skip <= SKIP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_cfg_w    <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg_h    <= i_cfg_data;
                CFG_SKIP:         r_cfg_skip <= i_cfg_data[W_SKIP-1:0];
                default: ;
            endcase
        end
    end

    // Sizes clamped to 1..8192, sample pitch skip+1
    always_comb begin
        if (r_cfg_w == '0)               wc = W_SIZE'(1);
        else if (r_cfg_w > SIZE_MAX_PIX) wc = SIZE_MAX_PIX;
        else                             wc = r_cfg_w;
        if (r_cfg_h == '0)               hc = W_SIZE'(1);
        else if (r_cfg_h > SIZE_MAX_PIX) hc = SIZE_MAX_PIX;
        else                             hc = r_cfg_h;
        step = {1'b0, r_cfg_skip} + (W_SKIP+1)'(1);
    end

    // ---------------- held request ----------------
    logic              accept;
    logic              r_it_op;
    logic [W_BYTE-1:0] r_it_r, r_it_g, r_it_b;
    logic [W_IDX-1:0]  r_it_idx;

    assign accept      = i_cmd.in_ready && i_in.valid;
    assign i_in.ready  = i_cmd.in_ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_it_op  <= i_in.operation;
            r_it_r   <= i_in.red;
            r_it_g   <= i_in.green;
            r_it_b   <= i_in.blue;
            r_it_idx <= i_in.bucket_index;
        end
    end

    // ---------------- serial divider ----------------
    logic [W_DVD-1:0]  r_dv_num, n_dv_num;
    logic [W_SIZE-1:0] r_dv_rem, n_dv_rem, r_dv_den;
    logic [W_DVC-1:0]  r_dv_cnt;
    logic              r_dv_busy;
    t_div_sel          r_dv_sel;
    logic [W_SIZE:0]   dv_trial, dv_diff;
    logic              dv_ge, dv_done;

    always_comb begin
        dv_trial = {r_dv_rem, r_dv_num[W_DVD-1]};
        dv_diff  = dv_trial - {1'b0, r_dv_den};
        dv_ge    = dv_trial >= {1'b0, r_dv_den};
        n_dv_rem = dv_ge ? dv_diff[W_SIZE-1:0] : dv_trial[W_SIZE-1:0];
        n_dv_num = {r_dv_num[W_DVD-2:0], dv_ge};
        dv_done  = r_dv_busy && (r_dv_cnt == W_DVC'(W_DVD-1));
    end

    // ---------------- position trackers ----------------
    logic [W_POS-1:0]  r_x, r_y, n_x, n_y;
    logic [W_SKIP-1:0] r_xm, r_ym, n_xm, n_ym;
    logic [W_SIZE-1:0] r_accx, r_accy, n_accx, n_accy;
    logic [BX_W-1:0]   r_bx, n_bx;
    logic [BY_W-1:0]   r_by, n_by;
    logic [W_SIZE-1:0] x_inc, y_inc, y_wr, accx_s, accy_s;
    logic [W_SKIP:0]   xm_inc, ym_inc;
    logic [A_W-1:0]    px_addr;
    logic              px_smp, adj_need;

    always_comb begin
        x_inc   = {1'b0, r_x} + W_SIZE'(1);
        y_inc   = {1'b0, r_y} + W_SIZE'(1);
        xm_inc  = {1'b0, r_xm} + (W_SKIP+1)'(1);
        ym_inc  = {1'b0, r_ym} + (W_SKIP+1)'(1);
        accx_s  = r_accx + W_SIZE'(GRID_WIDE);
        accy_s  = r_accy + W_SIZE'(GRID_HIGH);
        px_smp  = (r_xm == '0) && (r_ym == '0);
        px_addr = A_W'(32'(r_by) * GRID_WIDE + 32'(r_bx));
        adj_need = (r_accx >= wc) || (r_accy >= hc);
        y_wr    = ({1'b0, r_x} >= wc) ? y_inc : {1'b0, r_y};
    end

    always_comb begin
        n_x = r_x;   n_y = r_y;
        n_xm = r_xm; n_ym = r_ym;
        n_accx = r_accx; n_accy = r_accy;
        n_bx = r_bx; n_by = r_by;
        if (i_cmd.pos_clear) begin
            n_x = '0; n_y = '0; n_xm = '0; n_ym = '0;
            n_accx = '0; n_accy = '0; n_bx = '0; n_by = '0;
        end else if (i_cmd.wrap) begin
            // wrap a position left outside a resized frame
            if ({1'b0, r_x} >= wc) n_x = '0;
            n_y = (y_wr >= hc) ? '0 : y_wr[W_POS-1:0];
        end else if (dv_done) begin
            case (r_dv_sel)
                DV_XM: n_xm = n_dv_rem[W_SKIP-1:0];
                DV_YM: n_ym = n_dv_rem[W_SKIP-1:0];
                DV_XB: begin
                    n_bx   = n_dv_num[BX_W-1:0];
                    n_accx = n_dv_rem;
                end
                default: begin
                    n_by   = n_dv_num[BY_W-1:0];
                    n_accy = n_dv_rem;
                end
            endcase
        end else if (i_cmd.px_issue) begin
            if (x_inc >= wc) begin
                // end of row
                n_x = '0; n_xm = '0; n_accx = '0; n_bx = '0;
                if (y_inc >= hc) begin
                    n_y = '0; n_ym = '0; n_accy = '0; n_by = '0;
                end else begin
                    n_y  = y_inc[W_POS-1:0];
                    n_ym = (ym_inc == step) ? '0 : ym_inc[W_SKIP-1:0];
                    if (accy_s >= hc) begin
                        n_accy = accy_s - hc;
                        n_by   = r_by + BY_W'(1);
                    end else begin
                        n_accy = accy_s;
                    end
                end
            end else begin
                n_x  = x_inc[W_POS-1:0];
                n_xm = (xm_inc == step) ? '0 : xm_inc[W_SKIP-1:0];
                if (accx_s >= wc) begin
                    n_accx = accx_s - wc;
                    n_bx   = r_bx + BX_W'(1);
                end else begin
                    n_accx = accx_s;
                end
            end
        end else if (i_cmd.adjust) begin
            // extra carries when the grid is finer than the frame
            if (r_accx >= wc) begin
                n_accx = r_accx - wc;
                n_bx   = r_bx + BX_W'(1);
            end
            if (r_accy >= hc) begin
                n_accy = r_accy - hc;
                n_by   = r_by + BY_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0; r_y <= '0; r_xm <= '0; r_ym <= '0;
            r_accx <= '0; r_accy <= '0; r_bx <= '0; r_by <= '0;
            r_dirty   <= 1'b0;
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= '0;
        end else begin
            r_x <= n_x; r_y <= n_y; r_xm <= n_xm; r_ym <= n_ym;
            r_accx <= n_accx; r_accy <= n_accy; r_bx <= n_bx; r_by <= n_by;
            if (i_cfg_we)                                   r_dirty <= 1'b1;
            else if (i_cmd.pos_clear || i_cmd.resync_done)  r_dirty <= 1'b0;
            if (i_cmd.div_start) begin
                r_dv_busy <= 1'b1;
                r_dv_cnt  <= '0;
            end else if (r_dv_busy) begin
                r_dv_cnt <= r_dv_cnt + W_DVC'(1);
                if (dv_done) r_dv_busy <= 1'b0;
            end
        end
    end

    // Divider operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dv_sel <= i_cmd.div_sel;
            r_dv_rem <= '0;
            case (i_cmd.div_sel)
                DV_XM: begin
                    r_dv_num <= W_DVD'(r_x);
                    r_dv_den <= W_SIZE'(step);
                end
                DV_YM: begin
                    r_dv_num <= W_DVD'(r_y);
                    r_dv_den <= W_SIZE'(step);
                end
                DV_XB: begin
                    r_dv_num <= W_DVD'(32'(r_x) * GRID_WIDE);
                    r_dv_den <= wc;
                end
                default: begin
                    r_dv_num <= W_DVD'(32'(r_y) * GRID_HIGH);
                    r_dv_den <= hc;
                end
            endcase
        end else if (r_dv_busy) begin
            r_dv_num <= n_dv_num;
            r_dv_rem <= n_dv_rem;
        end
    end

    // ---------------- bucket memory ----------------
    t_bucket          r_mem [BUCKETS];
    t_bucket          r_rdata;
    t_bucket          mem_wdata;
    logic [A_W-1:0]   mem_waddr, mem_raddr, r_clr_addr, r_px_addr;
    logic             mem_we, mem_re, r_px_smp, clr_last;
    logic [15:0]      live_idx, held_idx;

    assign live_idx = 16'(i_in.bucket_index);
    assign held_idx = 16'(r_it_idx);
    assign clr_last = (r_clr_addr == A_W'(BUCKETS-1));

    // Port selection: clearing sweep or pixel update on write, pixel or request on read
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.px_write && r_px_smp && (r_rdata.count < COUNT_MAX)) begin
            mem_we          = 1'b1;
            mem_waddr       = r_px_addr;
            mem_wdata.red   = r_rdata.red   + W_SUM'(r_it_r);
            mem_wdata.green = r_rdata.green + W_SUM'(r_it_g);
            mem_wdata.blue  = r_rdata.blue  + W_SUM'(r_it_b);
            mem_wdata.count = r_rdata.count + W_CNT'(1);
        end
        mem_re = i_cmd.px_issue || i_cmd.rd_issue;
        if (i_cmd.px_issue)     mem_raddr = px_addr;
        else if (i_cmd.rd_live) mem_raddr = live_idx[A_W-1:0];
        else                    mem_raddr = held_idx[A_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= clr_last ? '0 : r_clr_addr + A_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.px_issue) begin
            r_px_addr <= px_addr;
            r_px_smp  <= px_smp;
        end
    end

    // ---------------- means: three restoring lanes, 8 steps ----------------
    t_bucket           r_cap, cap_n;
    logic [W_SUM-1:0]  r_m_rem [3];
    logic [W_SUM-1:0]  n_m_rem [3];
    logic [W_SUM-1:0]  cap_sum [3];
    logic [W_MEAN-1:0] r_m_q   [3];
    logic [W_SUM-1:0]  r_m_den;
    logic [2:0]        r_m_cnt;
    logic              m_ge    [3];
    logic              mean_last;

    assign mean_last = (r_m_cnt == 3'(W_MEAN-1));

    always_comb begin
        cap_n = (held_idx >= 16'(BUCKETS)) ? '0 : r_rdata;
        cap_sum[0] = cap_n.red;
        cap_sum[1] = cap_n.green;
        cap_sum[2] = cap_n.blue;
        for (int i = 0; i < 3; i++) begin
            m_ge[i]    = r_m_rem[i] >= r_m_den;
            n_m_rem[i] = m_ge[i] ? (r_m_rem[i] - r_m_den) : r_m_rem[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_capture) begin
            r_cap   <= cap_n;
            r_m_den <= W_SUM'({cap_n.count, {(W_MEAN-1){1'b0}}});
            r_m_cnt <= '0;
            for (int i = 0; i < 3; i++) begin
                r_m_rem[i] <= cap_sum[i];
                r_m_q[i]   <= '0;
            end
        end else if (i_cmd.mean_step) begin
            r_m_den <= r_m_den >> 1;
            r_m_cnt <= r_m_cnt + 3'd1;
            for (int i = 0; i < 3; i++) begin
                r_m_rem[i] <= n_m_rem[i];
                r_m_q[i]   <= {r_m_q[i][W_MEAN-2:0], m_ge[i]};
            end
        end
    end

    // ---------------- result register ----------------
    logic r_out_vld;
    logic out_free, cap_empty;

    assign out_free  = !r_out_vld || o_out.ready;
    assign cap_empty = (r_cap.count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out.red_sum      <= r_cap.red;
            o_out.green_sum    <= r_cap.green;
            o_out.blue_sum     <= r_cap.blue;
            o_out.sample_count <= r_cap.count;
            o_out.red_mean     <= cap_empty ? '0 : r_m_q[0];
            o_out.green_mean   <= cap_empty ? '0 : r_m_q[1];
            o_out.blue_mean    <= cap_empty ? '0 : r_m_q[2];
        end
    end

    assign o_out.valid = r_out_vld;

    // ---------------- status ----------------
    always_comb begin
        o_sts.in_valid  = i_in.valid;
        o_sts.in_op     = i_in.operation;
        o_sts.in_fs     = i_in.frame_start;
        o_sts.held_op   = r_it_op;
        o_sts.dirty     = r_dirty;
        o_sts.clr_last  = clr_last;
        o_sts.div_done  = dv_done;
        o_sts.adj_need  = adj_need;
        o_sts.mean_last = mean_last;
        o_sts.out_free  = out_free;
    end

    // A sampled pixel always maps inside the grid
    a_px_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.px_write && r_px_smp |-> (32'(r_px_addr) < BUCKETS))
        else $error("pixel bucket outside grid");

    // Trackers stay inside the frame whenever they are in sync with the config
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dirty && !adj_need |-> ({1'b0, r_x} < wc) && ({1'b0, r_y} < hc))
        else $error("position outside frame while trackers in sync");

    // Mean quotient fits in a byte: remainder ends below the count
    a_mean_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mean_step && mean_last && !cap_empty |=>
            (r_m_rem[0] < W_SUM'(r_cap.count)) && (r_m_rem[1] < W_SUM'(r_cap.count))
            && (r_m_rem[2] < W_SUM'(r_cap.count)))
        else $error("mean remainder not below count");

endmodule

`default_nettype wire

// ----- hdl/screen_grid_color_binning.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel    Port     Dir  Contents
// --------   ------   ---  ---------------------------------------------------
// request    i_in     in   operation, frame_start, red, green, blue, bucket_index
// result     o_out    out  red/green/blue sums, sample_count, red/green/blue means
// config     i_cfg_*  in   frame_width (0), frame_height (1), skip (2)
//
// Pixel: a bucket read, then its write, then an adjust step per extra tracker carry, which
// runs when the frame is narrower or shorter than the grid. After a config write the
// first pixel first wraps the position, then rebuilds the trackers with the serial divider.
// Read: bucket read, then the 8-step mean divider; holds its last state while a result waits.
// frame_start first zeroes all GRID_WIDE * GRID_HIGH buckets of the memory; the same
// sweep runs after reset and no request is taken until it ends.

module screen_grid_color_binning import scgb_pkg::*; #(
    parameter int GRID_WIDE = GRID_WIDE_DEF,
    parameter int GRID_HIGH = GRID_HIGH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [W_CFG_IX-1:0] i_cfg_idx,
    input  wire  [W_SIZE-1:0]   i_cfg_data,
    scgb_pix_if.sink            i_in,
    scgb_res_if.source          o_out
);

    t_cmd cmd;
    t_sts sts;

    scgb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    scgb_dpath #(
        .GRID_WIDE (GRID_WIDE),
        .GRID_HIGH (GRID_HIGH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

`default_nettype wire
